// ===== rtl/cpsl_pkg.sv =====
package cpsl_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int SPEED_W    = 16;
  localparam int ERR_W      = SPEED_W + 1;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int FRAC_W     = 8;
  localparam int PROD_W     = GAIN_W + 1 + ERR_W;
  localparam int DPROD_W    = GAIN_W + 1 + ERR_W + 1;
  localparam int INTEG_W    = 32;
  localparam int ISUM_W     = PROD_W + 1;
  localparam int SUM_W      = DPROD_W + 2;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd3328;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd768;
  localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 15'd8000;
  localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 15'd10000;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  integ_limit;
    logic [LIM_W-1:0]  drive_limit;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]           ch;
    logic                      ch_ok;
    logic signed [PROD_W-1:0]  p_term;
    logic signed [PROD_W-1:0]  i_step;
    logic signed [DPROD_W-1:0] d_term;
  } prod_t;

endpackage

// ===== rtl/cpsl_if.sv =====
interface cpsl_in_if import cpsl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CH_W-1:0]           channel;
  logic signed [SPEED_W-1:0] measured_speed;
  logic signed [SPEED_W-1:0] target_speed;

  modport source (output valid, channel, measured_speed, target_speed, input ready);
  modport sink (input valid, channel, measured_speed, target_speed, output ready);
endinterface

interface cpsl_out_if import cpsl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

interface cpsl_cfg_if import cpsl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/clamped_pid_speed_loop_core.sv =====
// Multi-channel PID speed loop with a clamped integrator and a clamped drive.
// Input beats on in_ch carry a channel number, a measured speed and a target
// speed. Each input beat gives exactly one output beat on out_ch with the
// drive value for that channel, in the order the input beats were taken.
// Gains and limits are written through cfg_ch, one register per beat; the
// channel is always ready, and writes belong in idle periods only.
// An output beat passes an input register, a register after the three gain
// multipliers, and the result register after the integrator update and the
// output clamp.
// Throughput is one beat per cycle while the receiver does not stall; the
// per-channel integrator is read and written in the final stage, so
// consecutive beats on the same channel do not wait for one another.
// Reset clears all integrators and previous errors, restores the default
// gains and limits, and empties the pipeline.
// When the receiver stalls, the result holds on out_ch and the stages behind
// it keep filling; in_ch.ready drops only once all three stages are full.
module clamped_pid_speed_loop_core import cpsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cpsl_in_if.sink    in_ch,
  cpsl_out_if.source out_ch,
  cpsl_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  prod_t prod;
  logic  prod_valid;
  logic  prod_ready;

  cpsl_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  cpsl_mult_stage u_mult_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .prod       (prod),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready)
  );

  cpsl_accum_stage u_accum_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod       (prod),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .cfg        (cfg),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/cpsl_cfg_regs.sv =====
module cpsl_cfg_regs import cpsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cpsl_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= PROP_GAIN_RST;
      cfg_r.integ_gain  <= INTEG_GAIN_RST;
      cfg_r.deriv_gain  <= DERIV_GAIN_RST;
      cfg_r.integ_limit <= INTEG_LIMIT_RST;
      cfg_r.drive_limit <= DRIVE_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_ch.data[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg_r.integ_gain  <= cfg_ch.data[GAIN_W-1:0];
        REG_DERIV_GAIN:  cfg_r.deriv_gain  <= cfg_ch.data[GAIN_W-1:0];
        REG_INTEG_LIMIT: cfg_r.integ_limit <= cfg_ch.data[LIM_W-1:0];
        REG_DRIVE_LIMIT: cfg_r.drive_limit <= cfg_ch.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cpsl_mult_stage.sv =====
module cpsl_mult_stage import cpsl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  cpsl_in_if.sink  in_ch,
  input  cfg_t     cfg,
  output prod_t    prod,
  output logic     prod_valid,
  input  logic     prod_ready
);

  logic                      s1_valid_r;
  logic [CH_W-1:0]           s1_ch_r;
  logic signed [SPEED_W-1:0] s1_meas_r;
  logic signed [SPEED_W-1:0] s1_targ_r;

  logic                      prod_valid_r;
  prod_t                     prod_r;
  prod_t                     prod_nxt;

  logic [CHANNELS-1:0][ERR_W-1:0] prev_err_r;

  logic                      s2_load;
  logic                      s1_free;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev;
  logic signed [ERR_W:0]     err_delta;
  logic signed [GAIN_W:0]    prop_gain_s;
  logic signed [GAIN_W:0]    integ_gain_s;
  logic signed [GAIN_W:0]    deriv_gain_s;

  assign s2_load      = s1_valid_r && (!prod_valid_r || prod_ready);
  assign s1_free      = !s1_valid_r || s2_load;
  assign in_ch.ready  = s1_free;
  assign prod         = prod_r;
  assign prod_valid   = prod_valid_r;

  always_comb begin
    prop_gain_s    = $signed({1'b0, cfg.prop_gain});
    integ_gain_s   = $signed({1'b0, cfg.integ_gain});
    deriv_gain_s   = $signed({1'b0, cfg.deriv_gain});
    err            = ERR_W'(s1_targ_r) - ERR_W'(s1_meas_r);
    prev           = $signed(prev_err_r[s1_ch_r]);
    err_delta      = (ERR_W + 1)'(err) - (ERR_W + 1)'(prev);
    prod_nxt.ch    = s1_ch_r;
    prod_nxt.ch_ok = (int'(s1_ch_r) < CHANNELS);
    prod_nxt.p_term = PROD_W'(prop_gain_s) * PROD_W'(err);
    prod_nxt.i_step = PROD_W'(integ_gain_s) * PROD_W'(err);
    prod_nxt.d_term = DPROD_W'(deriv_gain_s) * DPROD_W'(err_delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && s1_free) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_free) begin
      s1_ch_r   <= in_ch.channel;
      s1_meas_r <= in_ch.measured_speed;
      s1_targ_r <= in_ch.target_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (s2_load) begin
      prod_valid_r <= 1'b1;
    end else if (prod_ready) begin
      prod_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (s2_load && prod_nxt.ch_ok) begin
      prev_err_r[s1_ch_r] <= err;
    end
  end

  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && prod_valid_r && !prod_ready)
  ) else $error("Input stalled while the pipeline had room.");

  a_prev_err_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    !s2_load |=> $stable(prev_err_r)
  ) else $error("Previous error changed without a beat leaving the input stage.");

endmodule

// ===== rtl/cpsl_accum_stage.sv =====
module cpsl_accum_stage import cpsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  prod_t      prod,
  input  logic       prod_valid,
  output logic       prod_ready,
  input  cfg_t       cfg,
  cpsl_out_if.source out_ch
);

  logic [CHANNELS-1:0][INTEG_W-1:0] integ_r;
  logic                             out_valid_r;
  logic signed [DRIVE_W-1:0]        drive_r;
  logic signed [DRIVE_W-1:0]        drive_nxt;

  logic                       adv;
  logic signed [INTEG_W-1:0]  integ_cur;
  logic signed [ISUM_W-1:0]   integ_raw;
  logic signed [ISUM_W-1:0]   integ_lim;
  logic signed [ISUM_W-1:0]   integ_clip;
  logic signed [INTEG_W-1:0]  integ_new;
  logic signed [SUM_W-1:0]    sum_raw;
  logic signed [SUM_W-1:0]    sum_lim;
  logic signed [SUM_W-1:0]    sum_clip;
  logic signed [SUM_W-1:0]    sum_adj;

  assign prod_ready   = !out_valid_r || out_ch.ready;
  assign adv          = prod_valid && prod_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;

  always_comb begin
    integ_cur = $signed(integ_r[prod.ch]);
    integ_raw = ISUM_W'(integ_cur) + ISUM_W'(prod.i_step);
    integ_lim = $signed({{(ISUM_W - LIM_W - FRAC_W){1'b0}}, cfg.integ_limit,
                         {FRAC_W{1'b0}}});
    if (integ_raw > integ_lim) begin
      integ_clip = integ_lim;
    end else if (integ_raw < -integ_lim) begin
      integ_clip = -integ_lim;
    end else begin
      integ_clip = integ_raw;
    end
    integ_new = INTEG_W'(integ_clip);

    sum_raw = SUM_W'(prod.p_term) + SUM_W'(integ_new) + SUM_W'(prod.d_term);
    sum_lim = $signed({{(SUM_W - LIM_W - FRAC_W){1'b0}}, cfg.drive_limit,
                       {FRAC_W{1'b0}}});
    if (sum_raw > sum_lim) begin
      sum_clip = sum_lim;
    end else if (sum_raw < -sum_lim) begin
      sum_clip = -sum_lim;
    end else begin
      sum_clip = sum_raw;
    end

    // Negative sums are biased so the shift truncates toward zero.
    sum_adj = sum_clip + $signed(SUM_W'({FRAC_W{sum_clip[SUM_W-1]}}));
    if (prod.ch_ok) begin
      drive_nxt = sum_adj[FRAC_W +: DRIVE_W];
    end else begin
      drive_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (adv && prod.ch_ok) begin
      integ_r[prod.ch] <= integ_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_r <= drive_nxt;
    end
  end

  a_integ_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(integ_r)
  ) else $error("Integrator changed without a beat leaving the product stage.");

  a_bad_channel_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (adv && !prod.ch_ok) |=> (out_valid_r && drive_r == '0)
  ) else $error("Beat for an unused channel did not give a zero drive.");

endmodule
